// ===== design/acfr_pkg.sv =====
// Shared types and character codes for the ASCII command frame responder.
// No dependencies; every other design file imports this package.
package acfr_pkg;

  localparam int MAX_PAYLOAD_DEF  = 8;
  localparam int ADC_CHANNELS_DEF = 8;

  localparam logic [7:0] CH_BANG   = 8'h21;
  localparam logic [7:0] CH_AT     = 8'h40;
  localparam logic [7:0] CH_HASH   = 8'h23;
  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_TAIL   = 8'h7E;
  localparam logic [7:0] CH_QUERY  = 8'h3F;
  localparam logic [7:0] CH_DIGIT0 = 8'h30;
  localparam logic [7:0] CH_DIGIT1 = 8'h31;

  typedef struct packed {
    logic       cmd;
    logic [7:0] rx_byte;
    logic [7:0] switch_pins;
    logic [2:0] adc_channel;
    logic [7:0] adc_value;
  } acfr_in_t;

  typedef struct packed {
    logic       has_char;
    logic [7:0] tx_char;
    logic       last;
    logic [7:0] led_drive;
    logic [7:0] pwm_a_duty;
    logic [7:0] pwm_b_duty;
  } acfr_out_t;

  typedef enum logic [1:0] {
    RESP_NONE,
    RESP_ONE,
    RESP_LIST
  } resp_kind_t;

  typedef enum logic [1:0] {
    SEL_HEAD,
    SEL_DIGIT,
    SEL_TAIL,
    SEL_BLANK
  } char_sel_t;

  typedef struct packed {
    logic      load;
    logic      exec;
    logic      push;
    char_sel_t sel;
    logic      last;
  } ctrl_cmd_t;

  typedef struct packed {
    resp_kind_t kind;
    logic       digit_last;
    logic       chan_last;
    logic       out_free;
  } dp_stat_t;

endpackage

// ===== design/acfr_in_if.sv =====
// Input channel: valid/ready handshake carrying one input word.
// Depends on acfr_pkg.
interface acfr_in_if import acfr_pkg::*; ();
  logic     valid;
  logic     ready;
  acfr_in_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== design/acfr_out_if.sv =====
// Output channel: valid/ready handshake carrying one response word.
// Depends on acfr_pkg.
interface acfr_out_if import acfr_pkg::*; ();
  logic      valid;
  logic      ready;
  acfr_out_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== design/ascii_command_frame_responder.sv =====
// ASCII command frame responder, top level.
// Instantiates acfr_controller and acfr_datapath; depends on acfr_pkg and the
// acfr_in_if / acfr_out_if channel interfaces.
//
// req carries one word per received serial byte (cmd 0) or ADC sample update
// (cmd 1). rsp returns the response characters of that word one per word,
// the final one flagged by last; a word with no response yields one word
// with has_char low. Every rsp word also shows the current LED and PWM values.
// Timing with rsp.ready held high: after the req handshake the word is loaded,
// executed (S_EXEC) and classified (S_START) before the first response word
// is pushed; later ones follow one per cycle, and req reopens as the final
// word is loaded into the output register. The rate is set by the character
// sequencer, which emits one character per cycle.
// A stalled rsp holds its word; the sequencer waits, and req stays closed
// until the last word of the current response is in the output register.
// The next word may be accepted while that last word still waits.
// Synchronous reset clears the frame parser, frame store, ADC table, LED and
// PWM registers and the output valid flag; req is ready on the cycle after.
module ascii_command_frame_responder import acfr_pkg::*; #(
  parameter int MAX_PAYLOAD  = MAX_PAYLOAD_DEF,
  parameter int ADC_CHANNELS = ADC_CHANNELS_DEF
) (
  input logic       clk,
  input logic       rst,
  acfr_in_if.sink   req,
  acfr_out_if.source rsp
);

  ctrl_cmd_t cmd;
  dp_stat_t  stat;
  logic      ready;
  logic      out_valid;
  acfr_out_t out_data;

  assign req.ready = ready;
  assign rsp.valid = out_valid;
  assign rsp.data  = out_data;

  acfr_controller u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (req.valid),
    .in_ready (ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  acfr_datapath #(
    .MAX_PAYLOAD  (MAX_PAYLOAD),
    .ADC_CHANNELS (ADC_CHANNELS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .in_data   (req.data),
    .cmd       (cmd),
    .stat      (stat),
    .out_ready (rsp.ready),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule

// ===== design/acfr_datapath.sv =====
// Datapath: frame store, ADC table, LED/PWM registers, character generator
// and output register. Driven by acfr_controller; depends on acfr_pkg.
module acfr_datapath import acfr_pkg::*; #(
  parameter int MAX_PAYLOAD  = MAX_PAYLOAD_DEF,
  parameter int ADC_CHANNELS = ADC_CHANNELS_DEF
) (
  input  logic      clk,
  input  logic      rst,
  input  acfr_in_t  in_data,
  input  ctrl_cmd_t cmd,
  output dp_stat_t  stat,
  input  logic      out_ready,
  output logic      out_valid,
  output acfr_out_t out_data
);

  localparam int PCW = $clog2(MAX_PAYLOAD + 1);
  localparam int CW  = (ADC_CHANNELS > 1) ? $clog2(ADC_CHANNELS) : 1;
  localparam logic [CW-1:0] CHAN_MAX   = CW'(ADC_CHANNELS - 1);
  localparam logic [1:0]    DIGIT_LAST = 2'd2;

  function automatic logic [7:0] field_value(input logic [7:0] a, input logic [7:0] b,
                                             input logic [7:0] c);
    logic [7:0] ha;
    logic [7:0] tb;
    ha = 8'(8'(a - CH_DIGIT0) * 8'd100);
    tb = 8'(8'(b - CH_DIGIT0) * 8'd10);
    return 8'(ha + tb + 8'(c - CH_DIGIT0));
  endfunction

  function automatic logic [7:0] digit_char(input logic [7:0] v, input logic [1:0] pos);
    logic [1:0]  h;
    logic [6:0]  r;
    logic [14:0] p;
    logic [3:0]  t;
    logic [3:0]  o;
    logic [3:0]  d;
    h = (v >= 8'd200) ? 2'd2 : ((v >= 8'd100) ? 2'd1 : 2'd0);
    r = 7'(v - 8'(8'(h) * 8'd100));
    p = 15'(r) * 15'd205;              // r / 10 by reciprocal, exact for r < 100
    t = p[14:11];
    o = 4'(r - 7'(7'(t) * 7'd10));
    case (pos)
      2'd0:    d = {2'b00, h};
      2'd1:    d = t;
      default: d = o;
    endcase
    return 8'(CH_DIGIT0 + 8'(d));
  endfunction

  acfr_in_t      in_reg;
  logic          frame_active;
  logic [PCW-1:0] payload_count;
  logic [7:0]    frame_store [MAX_PAYLOAD+1];
  logic [7:0]    adc_table [ADC_CHANNELS];
  logic [7:0]    led_value;
  logic [7:0]    pwm_a_value;
  logic [7:0]    pwm_b_value;

  resp_kind_t    kind;
  logic [7:0]    head_char;
  logic          use_pins;
  logic [7:0]    pins_value;
  logic [CW-1:0] chan;
  logic [CW-1:0] chan_end;
  logic [1:0]    digit;

  logic [7:0]     hdr;
  logic [7:0]     sel;
  logic [7:0]     sel_off;
  logic           sel_ok;
  logic           is_header;
  logic           ch_ok;
  logic [PCW-1:0] pc_inc;
  logic [7:0]     fv1;
  logic [7:0]     fv2;
  logic [7:0]     fv4;
  logic [7:0]     cur_val;
  logic [7:0]     char_mux;

  assign hdr       = frame_store[0];
  assign sel       = frame_store[1];
  assign sel_off   = sel - CH_DIGIT0;
  assign sel_ok    = (sel >= CH_DIGIT0) && (sel_off < 8'(ADC_CHANNELS));
  assign is_header = in_reg.rx_byte inside {CH_BANG, CH_AT, CH_HASH, CH_DOLLAR};
  assign ch_ok     = {1'b0, in_reg.adc_channel} < 4'(ADC_CHANNELS);
  assign pc_inc    = payload_count + PCW'(1);
  assign fv1       = field_value(frame_store[1], frame_store[2], frame_store[3]);
  assign fv2       = field_value(frame_store[2], frame_store[3], frame_store[4]);
  assign fv4       = field_value(frame_store[4], frame_store[5], frame_store[6]);
  assign cur_val   = use_pins ? pins_value : adc_table[chan];

  always_comb begin
    case (cmd.sel)
      SEL_HEAD:  char_mux = head_char;
      SEL_DIGIT: char_mux = digit_char(cur_val, digit);
      SEL_TAIL:  char_mux = CH_TAIL;
      default:   char_mux = 8'd0;
    endcase
  end

  assign stat.kind       = kind;
  assign stat.digit_last = (digit == DIGIT_LAST);
  assign stat.chan_last  = (chan == chan_end);
  assign stat.out_free   = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_active  <= 1'b0;
      payload_count <= '0;
      led_value     <= '0;
      pwm_a_value   <= '0;
      pwm_b_value   <= '0;
      out_valid     <= 1'b0;
      for (int i = 0; i <= MAX_PAYLOAD; i++) begin
        frame_store[i] <= '0;
      end
      for (int i = 0; i < ADC_CHANNELS; i++) begin
        adc_table[i] <= '0;
      end
    end else begin
      if (cmd.load) begin
        in_reg <= in_data;
      end

      if (cmd.exec) begin
        kind  <= RESP_NONE;
        digit <= '0;
        if (in_reg.cmd) begin
          if (ch_ok) begin
            adc_table[in_reg.adc_channel[CW-1:0]] <= in_reg.adc_value;
          end
        end else if (!frame_active) begin
          if (is_header) begin
            payload_count  <= '0;
            frame_store[0] <= in_reg.rx_byte;
            frame_active   <= 1'b1;
          end
        end else if (in_reg.rx_byte == CH_TAIL) begin
          frame_active <= 1'b0;
          unique case (hdr)
            CH_BANG: begin
              kind       <= RESP_LIST;
              head_char  <= CH_BANG;
              use_pins   <= 1'b1;
              pins_value <= ~in_reg.switch_pins;
              chan       <= '0;
              chan_end   <= '0;
            end
            CH_AT: begin
              kind <= RESP_ONE;
              if (payload_count == PCW'(3)) begin
                head_char <= CH_AT;
                led_value <= ~fv1;
              end else begin
                head_char <= CH_QUERY;
              end
            end
            CH_HASH: begin
              if (payload_count == '0) begin
                kind      <= RESP_LIST;
                head_char <= CH_HASH;
                use_pins  <= 1'b0;
                chan      <= '0;
                chan_end  <= CHAN_MAX;
              end else if (sel_ok) begin
                kind      <= RESP_LIST;
                head_char <= CH_HASH;
                use_pins  <= 1'b0;
                chan      <= sel_off[CW-1:0];
                chan_end  <= sel_off[CW-1:0];
              end else begin
                kind      <= RESP_ONE;
                head_char <= CH_QUERY;
              end
            end
            CH_DOLLAR: begin
              if (payload_count == PCW'(6)) begin
                kind        <= RESP_ONE;
                head_char   <= CH_DOLLAR;
                pwm_a_value <= fv1;
                pwm_b_value <= fv4;
              end else if (sel == CH_DIGIT0 || sel == CH_DIGIT1) begin
                if (payload_count == PCW'(4)) begin
                  kind      <= RESP_ONE;
                  head_char <= CH_DOLLAR;
                  if (sel == CH_DIGIT0) begin
                    pwm_a_value <= fv2;
                  end else begin
                    pwm_b_value <= fv2;
                  end
                end
              end else begin
                kind      <= RESP_ONE;
                head_char <= CH_QUERY;
              end
            end
            default: begin
            end
          endcase
        end else if (payload_count >= PCW'(MAX_PAYLOAD)) begin
          frame_active <= 1'b0;
        end else begin
          payload_count       <= pc_inc;
          frame_store[pc_inc] <= in_reg.rx_byte;
        end
      end

      if (cmd.push && cmd.sel == SEL_DIGIT) begin
        if (digit == DIGIT_LAST) begin
          digit <= '0;
          if (chan != chan_end) begin
            chan <= chan + CW'(1);
          end
        end else begin
          digit <= digit + 2'd1;
        end
      end

      if (cmd.push) begin
        out_valid           <= 1'b1;
        out_data.has_char   <= (cmd.sel != SEL_BLANK);
        out_data.tx_char    <= char_mux;
        out_data.last       <= cmd.last;
        out_data.led_drive  <= led_value;
        out_data.pwm_a_duty <= pwm_a_value;
        out_data.pwm_b_duty <= pwm_b_value;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

// ===== design/acfr_controller.sv =====
// Controller: sequences load, update and character emission for each word.
// Talks to acfr_datapath through ctrl_cmd_t / dp_stat_t; depends on acfr_pkg.
module acfr_controller import acfr_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  dp_stat_t  stat,
  output ctrl_cmd_t cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_START,
    S_BLANK,
    S_ONE,
    S_HEAD,
    S_DIGIT,
    S_TAIL
  } state_t;

  state_t state;
  state_t state_next;

  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd.exec   = 1'b1;
        state_next = S_START;
      end
      S_START: begin
        unique case (stat.kind)
          RESP_ONE:  state_next = S_ONE;
          RESP_LIST: state_next = S_HEAD;
          default:   state_next = S_BLANK;
        endcase
      end
      S_BLANK: begin
        if (stat.out_free) begin
          cmd.push   = 1'b1;
          cmd.sel    = SEL_BLANK;
          cmd.last   = 1'b1;
          state_next = S_IDLE;
        end
      end
      S_ONE: begin
        if (stat.out_free) begin
          cmd.push   = 1'b1;
          cmd.sel    = SEL_HEAD;
          cmd.last   = 1'b1;
          state_next = S_IDLE;
        end
      end
      S_HEAD: begin
        if (stat.out_free) begin
          cmd.push   = 1'b1;
          cmd.sel    = SEL_HEAD;
          state_next = S_DIGIT;
        end
      end
      S_DIGIT: begin
        if (stat.out_free) begin
          cmd.push = 1'b1;
          cmd.sel  = SEL_DIGIT;
          if (stat.digit_last && stat.chan_last) begin
            state_next = S_TAIL;
          end
        end
      end
      S_TAIL: begin
        if (stat.out_free) begin
          cmd.push   = 1'b1;
          cmd.sel    = SEL_TAIL;
          cmd.last   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      in_ready <= 1'b1;
    end else begin
      state    <= state_next;
      in_ready <= (state_next == S_IDLE);
    end
  end

`ifndef SYNTHESIS
  a_push_free: assert property (@(posedge clk) disable iff (rst)
    cmd.push |-> stat.out_free)
    else $error("response word pushed into an occupied output register");

  a_load_exec: assert property (@(posedge clk) disable iff (rst)
    cmd.load |=> cmd.exec)
    else $error("accepted word not executed on the following cycle");

  a_last_ready: assert property (@(posedge clk) disable iff (rst)
    (cmd.push && cmd.last) |=> in_ready)
    else $error("input not reopened after the final response word");
`endif

endmodule
